@@ rtl/core/weighted_select_without_replacement_macros.svh @@
// Assertion macros used by the weighted select datapath.
`ifndef WEIGHTED_SELECT_WITHOUT_REPLACEMENT_MACROS_SVH
`define WEIGHTED_SELECT_WITHOUT_REPLACEMENT_MACROS_SVH

`ifndef SYNTHESIS
// Condition that must hold at every clock edge out of reset.
`define WSR_ASSERT_NOW(name, clk_s, rstn_s, prop) \
    name: assert property (@(posedge clk_s) disable iff (!rstn_s) (prop)) \
        else $error("wsr check failed");
// Condition that must hold in the cycle after a trigger.
`define WSR_ASSERT_NEXT(name, clk_s, rstn_s, pre, post) \
    name: assert property (@(posedge clk_s) disable iff (!rstn_s) (pre) |=> (post)) \
        else $error("wsr check failed");
`else
`define WSR_ASSERT_NOW(name, clk_s, rstn_s, prop)
`define WSR_ASSERT_NEXT(name, clk_s, rstn_s, pre, post)
`endif

`endif

@@ rtl/core/wsr_pkg.sv @@
// Shared types and constants of the weighted select block.
package wsr_pkg;

    // Request codes
    typedef enum logic [1:0] {
        REQ_APPEND = 2'd0,
        REQ_CLEAR  = 2'd1,
        REQ_BEGIN  = 2'd2,
        REQ_SELECT = 2'd3
    } req_t;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_NONE  = 2'd3
    } status_t;

    // Register indexes
    localparam logic REG_IDX_MODE = 1'b0;
    localparam logic REG_IDX_BASE = 1'b1;

    localparam logic        MODE_RESET = 1'b1;
    localparam logic [15:0] BASE_RESET = 16'd10000;

    // Result field widths
    localparam int OUT_PICK_W = 5;
    localparam int OUT_SUM_W  = 21;
    localparam int OUT_CNT_W  = 6;

    // Controller to datapath commands
    typedef struct packed {
        logic    start;
        logic    append;
        logic    clear;
        logic    begin_init;
        logic    begin_step;
        logic    must_read;
        logic    must_pop;
        logic    draw;
        logic    scan_step;
        logic    take;
        logic    out_load;
        status_t status;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic table_empty;
        logic table_full;
        logic must_avail;
        logic begin_done;
        logic hit;
        logic scan_done;
    } stat_t;

endpackage

@@ rtl/core/weighted_select_without_replacement.sv @@
// Top level of the weighted select block: register port, controller and datapath.
//
// Keeps a table of up to MAX_ENTRIES signed weights (negative marks a
// must-pick entry) and draws entries from it without replacement. One item is
// worked at a time and gives one result. Append and clear go from the accept
// directly to the result load state. Begin walks the table one entry per cycle
// through the table memory's read port, over the first min(table fill, 32)
// entries. A relative select that pops a must entry reads the must list and
// then pops it; otherwise a select first registers the draw multiply and then
// walks the candidate list one entry per cycle through the list memory's read
// port, stopping at the chosen entry. The next item is taken while a result
// waits in the output register; its result load then waits until that result
// is taken. No clearing pass after reset.
module weighted_select_without_replacement #(
    parameter int MAX_ENTRIES = 32,
    parameter int WEIGHT_BITS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [2:0]                      paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    input  logic                            req_valid,
    output logic                            req_ready,
    input  logic [1:0]                      req_type,
    input  logic signed [16:0]              weight,
    input  logic [31:0]                     entry_mask,
    input  logic [15:0]                     rand_fraction,
    output logic                            rsp_valid,
    input  logic                            rsp_ready,
    output logic [1:0]                      status,
    output logic [wsr_pkg::OUT_PICK_W-1:0]  picked_index,
    output logic [wsr_pkg::OUT_SUM_W-1:0]   remaining_sum,
    output logic [wsr_pkg::OUT_CNT_W-1:0]   remaining_count
);
    import wsr_pkg::*;

    logic        mode_reg;
    logic [15:0] base_reg;
    logic        cfg_write;
    cmd_t        cmd;
    stat_t       st;

    // Configuration registers
    assign cfg_write = psel && penable && pwrite;
    assign pready    = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_RESET;
            base_reg <= BASE_RESET;
        end
        else if (cfg_write)
        begin
            if (paddr[2] == REG_IDX_MODE)
                mode_reg <= pwdata[0];
            else
                base_reg <= pwdata[15:0];
        end
    end

    assign prdata = (paddr[2] == REG_IDX_BASE) ? {16'd0, base_reg} : {31'd0, mode_reg};

    wsr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_type  (req_type),
        .mode      (mode_reg),
        .st        (st),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready)
    );

    wsr_datapath #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .st              (st),
        .mode            (mode_reg),
        .absolute_base   (base_reg),
        .weight          (weight),
        .entry_mask      (entry_mask),
        .rand_fraction   (rand_fraction),
        .status          (status),
        .picked_index    (picked_index),
        .remaining_sum   (remaining_sum),
        .remaining_count (remaining_count)
    );

endmodule

@@ rtl/core/wsr_datapath.sv @@
// Datapath: weight table, candidate and must lists, sums, draw and scan logic.
`include "weighted_select_without_replacement_macros.svh"

module wsr_datapath #(
    parameter int MAX_ENTRIES = 32,
    parameter int WEIGHT_BITS = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  wsr_pkg::cmd_t                        cmd,
    output wsr_pkg::stat_t                       st,
    input  logic                                 mode,
    input  logic [15:0]                          absolute_base,
    input  logic signed [16:0]                   weight,
    input  logic [31:0]                          entry_mask,
    input  logic [15:0]                          rand_fraction,
    output logic [1:0]                           status,
    output logic [wsr_pkg::OUT_PICK_W-1:0]       picked_index,
    output logic [wsr_pkg::OUT_SUM_W-1:0]        remaining_sum,
    output logic [wsr_pkg::OUT_CNT_W-1:0]        remaining_count
);
    import wsr_pkg::*;

    localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int TW = $clog2(MAX_ENTRIES + 1);
    localparam int LD = (MAX_ENTRIES < 32) ? MAX_ENTRIES : 32;
    localparam int LA = $clog2(LD);
    localparam int PW = $clog2(LD + 1);
    localparam int SW = WEIGHT_BITS + 6;
    localparam int DW = SW + 1;
    localparam int MW = DW + 16;
    localparam int EW = WEIGHT_BITS + 1;
    localparam int CE = IW + WEIGHT_BITS;
    localparam int XS = SW + OUT_SUM_W;
    localparam int XT = TW + 1;
    localparam logic [31:0] WMAX = 32'((64'd1 << WEIGHT_BITS) - 64'd1);
    localparam logic [OUT_SUM_W-1:0] SUM_MAX = '1;

    // Storage
    logic [EW-1:0] tbl_mem [MAX_ENTRIES];
    logic [CE-1:0] cand_mem [LD];
    logic [IW-1:0] must_mem [LD];

    logic [TW-1:0]          tc_reg;
    logic [PW-1:0]          cc_reg;
    logic [PW-1:0]          mc_reg;
    logic [SW-1:0]          sum_reg;
    logic [PW-1:0]          ptr_reg;
    logic [31:0]            mask_reg;
    logic [15:0]            frac_reg;
    logic [IW-1:0]          pick_reg;
    logic                   bp_reg;
    logic                   sp_reg;
    logic [EW-1:0]          tbl_rd_reg;
    logic [IW-1:0]          bidx_reg;
    logic [CE-1:0]          cand_rd_reg;
    logic [LA-1:0]          pos_reg;
    logic [CE-1:0]          last_reg;
    logic [IW-1:0]          must_first_reg;
    logic [IW-1:0]          must_last_reg;
    logic [MW-1:0]          prod_reg;
    logic                   off_reg;
    logic [DW-1:0]          run_reg;
    logic [1:0]             status_reg;
    logic [OUT_PICK_W-1:0]  pick_out_reg;
    logic [OUT_SUM_W-1:0]   sum_out_reg;
    logic [OUT_CNT_W-1:0]   cnt_out_reg;

    logic [TW-1:0]          begin_lim;
    logic                   begin_issue;
    logic                   scan_issue;
    logic                   scan_match;
    logic                   hit;
    logic [WEIGHT_BITS-1:0] app_value;
    logic [31:0]            app_u32;
    logic [IW-1:0]          scan_idx;
    logic [WEIGHT_BITS-1:0] scan_w;
    logic [DW-1:0]          draw_d;
    logic [DW-1:0]          run_sum;
    logic [DW-1:0]          draw_op;
    logic                   keep;

    // Append value, saturated to the weight width
    assign app_u32   = 32'(weight[15:0]);
    assign app_value = (app_u32 > WMAX) ? WEIGHT_BITS'(WMAX) : WEIGHT_BITS'(app_u32);

    // Begin scan covers entries below both the fill and the mask width
    assign begin_lim   = (tc_reg > TW'(LD)) ? TW'(LD) : tc_reg;
    assign begin_issue = cmd.begin_step && (TW'(ptr_reg) < begin_lim);

    // Candidate scan compare; a fetched entry is only pending during the scan
    assign scan_idx = cand_rd_reg[CE-1:WEIGHT_BITS];
    assign scan_w   = cand_rd_reg[WEIGHT_BITS-1:0];
    assign draw_d   = DW'(prod_reg >> 16) + DW'(off_reg);
    assign run_sum  = run_reg + DW'(scan_w);
    assign scan_match = sp_reg &&
                        (mode ? (draw_d <= run_sum) : (draw_d <= DW'(scan_w)));
    assign hit      = cmd.scan_step && scan_match;
    assign scan_issue = cmd.scan_step && (ptr_reg < cc_reg) && !hit;
    assign draw_op  = mode ? (DW'(sum_reg) + DW'(1)) : DW'(absolute_base);
    assign keep     = mask_reg[5'(bidx_reg)];

    always_comb
    begin
        st.table_empty = (tc_reg == '0);
        st.table_full  = (tc_reg == TW'(MAX_ENTRIES));
        st.must_avail  = (mc_reg != '0);
        st.begin_done  = !(TW'(ptr_reg) < begin_lim) && !bp_reg;
        st.hit         = scan_match;
        st.scan_done   = !(ptr_reg < cc_reg) && !sp_reg;
    end

    // Weight table
    always_ff @(posedge clk)
    begin
        if (cmd.append)
        begin
            tbl_mem[IW'(tc_reg)] <= weight[16] ? {1'b1, {WEIGHT_BITS{1'b0}}}
                                               : {1'b0, app_value};
        end
        if (begin_issue)
        begin
            tbl_rd_reg <= tbl_mem[IW'(ptr_reg)];
            bidx_reg   <= IW'(ptr_reg);
        end
    end

    // Candidate list: entry index and its weight
    always_ff @(posedge clk)
    begin
        if (cmd.begin_step && bp_reg && keep && !tbl_rd_reg[EW-1])
        begin
            cand_mem[LA'(cc_reg)] <= {bidx_reg, tbl_rd_reg[WEIGHT_BITS-1:0]};
        end
        else if (cmd.take)
        begin
            cand_mem[pos_reg] <= last_reg;
        end
        if (scan_issue)
        begin
            cand_rd_reg <= cand_mem[LA'(ptr_reg)];
            pos_reg     <= LA'(ptr_reg);
        end
        if (cmd.draw)
        begin
            last_reg <= cand_mem[LA'(cc_reg - PW'(1))];
        end
    end

    // Must list
    always_ff @(posedge clk)
    begin
        if (cmd.begin_step && bp_reg && keep && tbl_rd_reg[EW-1])
        begin
            must_mem[LA'(mc_reg)] <= bidx_reg;
        end
        else if (cmd.must_pop)
        begin
            must_mem[LA'(0)] <= must_last_reg;
        end
        if (cmd.must_read)
        begin
            must_first_reg <= must_mem[LA'(0)];
            must_last_reg  <= must_mem[LA'(mc_reg - PW'(1))];
        end
    end

    // Draw product and running sum
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            mask_reg <= entry_mask;
            frac_reg <= rand_fraction;
        end
        if (cmd.draw)
        begin
            prod_reg <= MW'(draw_op) * MW'(frac_reg);
            off_reg  <= !mode && (absolute_base != '0);
            run_reg  <= '0;
        end
        else if (cmd.scan_step && sp_reg && !hit)
        begin
            run_reg <= run_sum;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            status_reg   <= cmd.status;
            pick_out_reg <= OUT_PICK_W'(pick_reg);
            sum_out_reg  <= (XS'(sum_reg) > XS'(SUM_MAX)) ? SUM_MAX : OUT_SUM_W'(sum_reg);
            cnt_out_reg  <= OUT_CNT_W'(cc_reg) + OUT_CNT_W'(mc_reg);
        end
    end

    // Counters, sum and scan pointer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tc_reg   <= '0;
            cc_reg   <= '0;
            mc_reg   <= '0;
            sum_reg  <= '0;
            ptr_reg  <= '0;
            bp_reg   <= 1'b0;
            sp_reg   <= 1'b0;
            pick_reg <= '0;
        end
        else
        begin
            bp_reg <= begin_issue;
            sp_reg <= scan_issue;
            if (cmd.start)
            begin
                pick_reg <= '0;
            end
            if (cmd.append)
            begin
                tc_reg <= tc_reg + TW'(1);
            end
            if (cmd.clear)
            begin
                tc_reg  <= '0;
                cc_reg  <= '0;
                mc_reg  <= '0;
                sum_reg <= '0;
            end
            if (cmd.begin_init)
            begin
                cc_reg  <= '0;
                mc_reg  <= '0;
                sum_reg <= '0;
                ptr_reg <= '0;
            end
            if (cmd.draw)
            begin
                ptr_reg <= '0;
            end
            if (begin_issue || scan_issue)
            begin
                ptr_reg <= ptr_reg + PW'(1);
            end
            // Sort one fetched table entry into its list
            if (cmd.begin_step && bp_reg && keep)
            begin
                if (tbl_rd_reg[EW-1])
                begin
                    mc_reg <= mc_reg + PW'(1);
                end
                else
                begin
                    cc_reg  <= cc_reg + PW'(1);
                    sum_reg <= sum_reg + SW'(tbl_rd_reg[WEIGHT_BITS-1:0]);
                end
            end
            if (cmd.must_pop)
            begin
                mc_reg   <= mc_reg - PW'(1);
                pick_reg <= must_first_reg;
            end
            if (hit)
            begin
                pick_reg <= scan_idx;
            end
            // Remove the chosen candidate
            if (cmd.take)
            begin
                cc_reg  <= cc_reg - PW'(1);
                sum_reg <= (sum_reg >= SW'(scan_w)) ? (sum_reg - SW'(scan_w)) : '0;
            end
        end
    end

    assign status          = status_reg;
    assign picked_index    = pick_out_reg;
    assign remaining_sum   = sum_out_reg;
    assign remaining_count = cnt_out_reg;

    `WSR_ASSERT_NOW(a_lists_within_table, clk, rst_n, (XT'(cc_reg) + XT'(mc_reg)) <= XT'(tc_reg))
    `WSR_ASSERT_NEXT(a_take_shrinks_list, clk, rst_n, cmd.take, cc_reg == ($past(cc_reg) - PW'(1)))
    `WSR_ASSERT_NOW(a_empty_list_no_sum, clk, rst_n, (cc_reg == '0) |-> (sum_reg == '0))

endmodule

@@ rtl/core/wsr_ctrl.sv @@
// Controller: sequences each item and owns the result handshake.
module wsr_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  logic [1:0]     req_type,
    input  logic           mode,
    input  wsr_pkg::stat_t st,
    output wsr_pkg::cmd_t  cmd,
    output logic           rsp_valid,
    input  logic           rsp_ready
);
    import wsr_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_BEGIN_RUN,
        S_MUST_RD,
        S_MUST_WR,
        S_DRAW,
        S_SCAN,
        S_TAKE,
        S_FIN
    } state_t;

    state_t  state_reg, state_next;
    status_t status_reg, status_next;
    logic    rsp_valid_reg, rsp_valid_next;

    // Next state and commands
    always_comb
    begin
        cmd            = '0;
        cmd.status     = status_reg;
        state_next     = state_reg;
        status_next    = status_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.start   = 1'b1;
                    status_next = ST_OK;
                    state_next  = S_FIN;
                    unique case (req_t'(req_type))
                        REQ_APPEND:
                        begin
                            if (st.table_full)
                                status_next = ST_FULL;
                            else
                                cmd.append = 1'b1;
                        end
                        REQ_CLEAR:
                        begin
                            cmd.clear = 1'b1;
                        end
                        REQ_BEGIN:
                        begin
                            if (st.table_empty)
                                status_next = ST_EMPTY;
                            else
                            begin
                                cmd.begin_init = 1'b1;
                                state_next     = S_BEGIN_RUN;
                            end
                        end
                        REQ_SELECT:
                        begin
                            priority if (st.table_empty)
                                status_next = ST_EMPTY;
                            else if (mode && st.must_avail)
                                state_next = S_MUST_RD;
                            else
                                state_next = S_DRAW;
                        end
                        default:
                        begin
                            status_next = ST_OK;
                        end
                    endcase
                end
            end
            S_BEGIN_RUN:
            begin
                cmd.begin_step = 1'b1;
                if (st.begin_done)
                    state_next = S_FIN;
            end
            S_MUST_RD:
            begin
                cmd.must_read = 1'b1;
                state_next    = S_MUST_WR;
            end
            S_MUST_WR:
            begin
                cmd.must_pop = 1'b1;
                state_next   = S_FIN;
            end
            S_DRAW:
            begin
                cmd.draw   = 1'b1;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                priority if (st.hit)
                    state_next = S_TAKE;
                else if (st.scan_done)
                begin
                    status_next = ST_NONE;
                    state_next  = S_FIN;
                end
            end
            S_TAKE:
            begin
                cmd.take   = 1'b1;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                // Load the result once the output register is free
                if (!rsp_valid_reg || rsp_ready)
                begin
                    cmd.out_load   = 1'b1;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            status_reg    <= ST_OK;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            status_reg    <= status_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;

endmodule

@@ dv/tb_weighted_select_without_replacement.sv @@
// Self-checking testbench for the weighted select without replacement block.
module tb_weighted_select_without_replacement;
    timeunit 1ns;
    timeprecision 1ps;
    import wsr_pkg::*;

    localparam int N_ENT = 32;
    localparam int WMAX = 65535;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 60;
    localparam logic [2:0] ADDR_MODE = 3'(REG_IDX_MODE) * 3'd4;
    localparam logic [2:0] ADDR_BASE = 3'(REG_IDX_BASE) * 3'd4;

    typedef struct packed {
        logic [1:0]  st;
        logic [4:0]  pick;
        logic [20:0] rsum;
        logic [5:0]  rcnt;
    } pick_result_t;

    typedef struct {
        req_t        op;
        logic [16:0] w;
        logic [31:0] mask;
        logic [15:0] frac;
        logic        has_exp;
        pick_result_t exp;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic req_valid = 1'b0, req_ready;
    logic [1:0] req_type = '0;
    logic signed [16:0] weight = '0;
    logic [31:0] entry_mask = '0;
    logic [15:0] rand_fraction = '0;
    logic rsp_valid, rsp_ready = 1'b0;
    logic [1:0] status;
    logic [4:0] picked_index;
    logic [20:0] remaining_sum;
    logic [5:0] remaining_count;

    weighted_select_without_replacement i_dut (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .req_valid(req_valid), .req_ready(req_ready), .req_type(req_type),
        .weight(weight), .entry_mask(entry_mask), .rand_fraction(rand_fraction),
        .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .status(status),
        .picked_index(picked_index), .remaining_sum(remaining_sum),
        .remaining_count(remaining_count)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Predictor state
    logic        sel_mode;
    logic [15:0] sel_base;
    logic        tbl_must [N_ENT];
    logic [16:0] tbl_val [N_ENT];
    int          tbl_fill, cand_n, must_n;
    int          cand_idx [N_ENT];
    int          must_idx [N_ENT];
    longint      wsum;

    pick_result_t pending_results [$];
    int fail_count = 0;
    int send_idle_pct = 0, recv_idle_pct = 0;
    int idle_cycles = 0;

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    function automatic pick_result_t pack_result(input logic [1:0] st, input int idx);
        pick_result_t r;
        longint cnt;
        cnt = cand_n + must_n;
        r.st = st;
        r.pick = 5'(idx);
        r.rsum = (wsum > 64'h1FFFFF) ? 21'h1FFFFF : 21'(wsum);
        r.rcnt = (cnt > 63) ? 6'd63 : 6'(cnt);
        return r;
    endfunction

    function automatic longint scaled_draw(input longint lo, input longint hi,
                                           input logic [15:0] f);
        if (lo > hi)
            return hi;
        return lo + (((hi - lo + 1) * longint'(f)) >>> 16);
    endfunction

    function automatic void remove_cand(input int pos);
        longint wv;
        wv = tbl_val[cand_idx[pos]];
        wsum = (wsum >= wv) ? wsum - wv : 0;
        cand_idx[pos] = cand_idx[cand_n - 1];
        cand_n--;
    endfunction

    // Expected result of one item, with state update
    function automatic pick_result_t predict_pick(input req_t op, input logic [16:0] w,
                                                  input logic [31:0] mask,
                                                  input logic [15:0] f);
        longint d, run;
        int e;
        if (op == REQ_APPEND)
        begin
            if (tbl_fill >= N_ENT)
                return pack_result(ST_FULL, 0);
            tbl_must[tbl_fill] = w[16];
            tbl_val[tbl_fill] = w[16] ? 17'd0 : ((w > WMAX) ? 17'(WMAX) : w);
            tbl_fill++;
            return pack_result(ST_OK, 0);
        end
        if (op == REQ_CLEAR)
        begin
            tbl_fill = 0; cand_n = 0; must_n = 0; wsum = 0;
            return pack_result(ST_OK, 0);
        end
        if (tbl_fill == 0)
            return pack_result(ST_EMPTY, 0);
        if (op == REQ_BEGIN)
        begin
            cand_n = 0; must_n = 0; wsum = 0;
            for (int i = 0; i < tbl_fill; i++)
            begin
                if (!mask[i])
                    continue;
                if (tbl_must[i])
                    must_idx[must_n++] = i;
                else
                begin
                    cand_idx[cand_n++] = i;
                    wsum += tbl_val[i];
                end
            end
            return pack_result(ST_OK, 0);
        end
        if (sel_mode)
        begin
            if (must_n > 0)
            begin
                e = must_idx[0];
                must_idx[0] = must_idx[must_n - 1];
                must_n--;
                return pack_result(ST_OK, e);
            end
            d = scaled_draw(0, wsum, f);
            run = 0;
            for (int i = 0; i < cand_n; i++)
            begin
                e = cand_idx[i];
                run += tbl_val[e];
                if (d <= run)
                begin
                    remove_cand(i);
                    return pack_result(ST_OK, e);
                end
            end
        end
        else
        begin
            d = scaled_draw(1, sel_base, f);
            for (int i = 0; i < cand_n; i++)
            begin
                e = cand_idx[i];
                if (d <= tbl_val[e])
                begin
                    remove_cand(i);
                    return pack_result(ST_OK, e);
                end
            end
        end
        return pack_result(ST_NONE, 0);
    endfunction

    // Register write: setup cycle then access cycle
    task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
        @(negedge clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (addr == ADDR_MODE)
            sel_mode = data[0];
        else
            sel_base = data[15:0];
    endtask

    // Block is idle once results are drained and trailing work has settled
    task automatic wait_idle();
        req_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Drive one item, wait for accept; optional literal expectation
    task automatic send_item(input req_t op, input logic [16:0] w, input logic [31:0] mask,
                             input logic [15:0] f, input logic has_exp,
                             input pick_result_t lit);
        pick_result_t p;
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1; req_type <= op; weight <= w;
        entry_mask <= mask; rand_fraction <= f;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        p = predict_pick(op, w, mask, f);
        if (has_exp && p != lit)
            report_mismatch("directed row vs predictor", p, lit);
        pending_results.push_back(has_exp ? lit : p);
        @(negedge clk);
    endtask

    // Receiver side: random stall, check on accept
    always @(negedge clk)
        rsp_ready <= ($urandom_range(99) >= recv_idle_pct);

    always @(posedge clk)
    begin
        pick_result_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (pending_results.size() == 0)
                report_mismatch("unexpected result status", status, -1);
            else
            begin
                want = pending_results.pop_front();
                if (status != want.st) report_mismatch("status", status, want.st);
                if (picked_index != want.pick)
                    report_mismatch("picked_index", picked_index, want.pick);
                if (remaining_sum != want.rsum)
                    report_mismatch("remaining_sum", remaining_sum, want.rsum);
                if (remaining_count != want.rcnt)
                    report_mismatch("remaining_count", remaining_count, want.rcnt);
            end
        end
    end

    // Watchdog on cycles without any accepted item, taken result or register access
    always @(posedge clk)
    begin
        if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic logic [16:0] rand_weight();
        case ($urandom_range(9))
            0: return 17'h1FFFF;
            1: return 17'(WMAX);
            2: return 17'($urandom_range(65535)) | 17'h10000;
            3: return 17'($urandom_range(15));
            default: return 17'($urandom_range(65535));
        endcase
    endfunction

    // A clear-fill-begin-select round with random content
    task automatic random_round(input int sel_count);
        int n;
        n = $urandom_range(12, 1);
        if ($urandom_range(9) == 0)
            n = 34;
        send_item(REQ_CLEAR, 17'($urandom), $urandom, 16'($urandom), 1'b0, '0);
        for (int i = 0; i < n; i++)
            send_item(REQ_APPEND, rand_weight(), $urandom, 16'($urandom), 1'b0, '0);
        send_item(REQ_BEGIN, 17'($urandom),
                  ($urandom_range(3) == 0) ? $urandom : 32'hFFFFFFFF, 16'($urandom),
                  1'b0, '0);
        for (int i = 0; i < sel_count; i++)
            send_item(REQ_SELECT, 17'($urandom), $urandom, 16'($urandom), 1'b0, '0);
    endtask

    stim_row_t rows [$];

    function automatic stim_row_t mk(input req_t op, input logic [16:0] w,
                                     input logic [31:0] m, input logic [15:0] f,
                                     input logic h, input pick_result_t e);
        stim_row_t r;
        r.op = op; r.w = w; r.mask = m; r.frac = f; r.has_exp = h; r.exp = e;
        return r;
    endfunction

    initial
    begin
        sel_mode = MODE_RESET; sel_base = BASE_RESET;
        tbl_fill = 0; cand_n = 0; must_n = 0; wsum = 0;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed table: empty table, extremes, must entries
        rows.push_back(mk(REQ_SELECT, 0, 0, 0, 1, '{ST_EMPTY, 0, 0, 0}));
        rows.push_back(mk(REQ_BEGIN, 0, 32'hFFFFFFFF, 0, 1, '{ST_EMPTY, 0, 0, 0}));
        rows.push_back(mk(REQ_APPEND, 17'h1FFFF, 0, 0, 1, '{ST_OK, 0, 0, 0}));
        rows.push_back(mk(REQ_APPEND, 17'(WMAX), 0, 0, 1, '{ST_OK, 0, 0, 0}));
        rows.push_back(mk(REQ_APPEND, 17'd0, 0, 0, 1, '{ST_OK, 0, 0, 0}));
        rows.push_back(mk(REQ_APPEND, 17'h10000, 0, 0, 1, '{ST_OK, 0, 0, 0}));
        rows.push_back(mk(REQ_APPEND, 17'd7, 0, 0, 1, '{ST_OK, 0, 0, 0}));
        rows.push_back(mk(REQ_BEGIN, 0, 32'hFFFFFFFF, 0, 0, '0));
        rows.push_back(mk(REQ_SELECT, 0, 0, 16'hFFFF, 0, '0));
        rows.push_back(mk(REQ_SELECT, 0, 0, 16'h0000, 0, '0));
        rows.push_back(mk(REQ_SELECT, 0, 0, 16'hFFFF, 0, '0));
        rows.push_back(mk(REQ_SELECT, 0, 0, 16'h8000, 0, '0));
        rows.push_back(mk(REQ_SELECT, 0, 0, 16'h1234, 0, '0));
        rows.push_back(mk(REQ_SELECT, 0, 0, 16'h0000, 0, '0));
        rows.push_back(mk(REQ_BEGIN, 0, 32'h0, 0, 0, '0));
        rows.push_back(mk(REQ_SELECT, 0, 32'hFFFFFFFF, 16'hFFFF, 1, '{ST_NONE, 0, 0, 0}));
        rows.push_back(mk(REQ_CLEAR, 17'h1FFFF, 32'hFFFFFFFF, 16'hFFFF, 1, '{ST_OK, 0, 0, 0}));
        foreach (rows[i])
            send_item(rows[i].op, rows[i].w, rows[i].mask, rows[i].frac,
                      rows[i].has_exp, rows[i].exp);
        // Fill past capacity
        for (int i = 0; i < 33; i++)
            send_item(REQ_APPEND, 17'(i + 1), 0, 0, 1'b0, '0);
        wait_idle();

        // Absolute mode at both base extremes
        write_reg(ADDR_MODE, 32'd0);
        write_reg(ADDR_BASE, 32'd0);
        send_item(REQ_BEGIN, 0, 32'hFFFFFFFF, 0, 1'b0, '0);
        send_item(REQ_SELECT, 0, 0, 16'hFFFF, 1'b0, '0);
        wait_idle();
        write_reg(ADDR_BASE, 32'hFFFFFFFF);
        send_item(REQ_SELECT, 0, 0, 16'hFFFF, 1'b0, '0);
        send_item(REQ_SELECT, 0, 0, 16'h0000, 1'b0, '0);
        wait_idle();

        // Random phases across idle profiles and register settings
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph % 3)
                0: begin send_idle_pct = 11; recv_idle_pct = 83; end
                1: begin send_idle_pct = 83; recv_idle_pct = 11; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            wait_idle();
            write_reg(ADDR_MODE, (ph < 3) ? 32'd1 : 32'd0);
            write_reg(ADDR_BASE, (ph == 4) ? 32'd65535 :
                      (ph == 5) ? 32'd1 : 32'($urandom_range(65535, 1)));
            for (int k = 0; k < 7; k++)
            begin
                random_round($urandom_range(14, 1));
                // Noise item of random kind
                send_item(req_t'($urandom_range(3)), 17'($urandom), $urandom,
                          16'($urandom), 1'b0, '0);
                if (k == 4)
                begin
                    req_valid <= 1'b0;
                    do
                        @(negedge clk);
                    while (pending_results.size() != 0);
                end
            end
        end

        wait_idle();
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
